/* rtl/sobb_pkg.sv */
package sobb_pkg;

    localparam int SLOT_W  = 16;
    localparam int REG_W   = 48;
    localparam int HALF_W  = 15;
    localparam int RAD_W   = 15;
    localparam int T_W     = HALF_W + 1;
    localparam int Q_W     = 2 * SLOT_W;
    localparam int O_W     = Q_W + 2;
    localparam int R_W     = 16;
    localparam int SQ_W    = 2 * HALF_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int FAR_MAX = 32767;

    typedef enum logic [2:0] {
        REG_CENTER = 3'd0,
        REG_AXIS0  = 3'd1,
        REG_AXIS1  = 3'd2,
        REG_AXIS2  = 3'd3,
        REG_HALF   = 3'd4
    } sobb_reg_t;

    typedef struct packed {
        logic [REG_W-1:0] half;
        logic [REG_W-1:0] axis2;
        logic [REG_W-1:0] axis1;
        logic [REG_W-1:0] axis0;
        logic [REG_W-1:0] center;
    } sobb_cfg_t;

    localparam logic [REG_W-1:0] AXIS0_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] AXIS1_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] AXIS2_RST = 48'h4000_0000_0000;

    localparam sobb_cfg_t CFG_RST = '{
        half:   '0,
        axis2:  AXIS2_RST,
        axis1:  AXIS1_RST,
        axis0:  AXIS0_RST,
        center: '0
    };

    function automatic logic signed [SLOT_W-1:0] slot(input logic [REG_W-1:0] value,
                                                      input int k);
        return $signed(value[k*SLOT_W +: SLOT_W]);
    endfunction

    function automatic logic [HALF_W-1:0] half_slot(input logic [REG_W-1:0] value,
                                                    input int k);
        return value[k*SLOT_W +: HALF_W];
    endfunction

    function automatic int d_width(input int cw);
        return ((cw > SLOT_W) ? cw : SLOT_W) + 1;
    endfunction

endpackage

/* rtl/sobb_cfg.sv */
module sobb_cfg
    import sobb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output sobb_cfg_t         cfg
);

    sobb_cfg_t cfg_reg;
    sobb_cfg_t cfg_next;
    sobb_reg_t sel;
    logic      wr_en;

    assign sel   = sobb_reg_t'(paddr[ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                REG_CENTER: cfg_next.center = pwdata[REG_W-1:0];
                REG_AXIS0:  cfg_next.axis0  = pwdata[REG_W-1:0];
                REG_AXIS1:  cfg_next.axis1  = pwdata[REG_W-1:0];
                REG_AXIS2:  cfg_next.axis2  = pwdata[REG_W-1:0];
                REG_HALF:   cfg_next.half   = pwdata[REG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_CENTER: prdata = DATA_W'(cfg_reg.center);
            REG_AXIS0:  prdata = DATA_W'(cfg_reg.axis0);
            REG_AXIS1:  prdata = DATA_W'(cfg_reg.axis1);
            REG_AXIS2:  prdata = DATA_W'(cfg_reg.axis2);
            REG_HALF:   prdata = DATA_W'(cfg_reg.half);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/sobb_proj.sv */
module sobb_proj
    import sobb_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int AXIS_FRAC_BITS = 14,
    localparam int DW = d_width(COORD_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0][COORD_WIDTH-1:0] sphere,
    input  logic [RAD_W-1:0]            radius,
    input  sobb_cfg_t                   cfg,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0][DW-1:0]          d_out,
    output logic [2:0][T_W-1:0]         t_out,
    output logic [RAD_W-1:0]            rad_out
);

    localparam int PRW = DW + SLOT_W;
    localparam int SW  = PRW + 2;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [DW-1:0]  d1_reg [3];
    logic signed [DW-1:0]  d2_reg [3];
    logic signed [DW-1:0]  d3_reg [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [PRW-1:0] prod_reg  [3][3];
    logic signed [PRW-1:0] prod_next [3][3];
    logic signed [T_W-1:0] t_reg  [3];
    logic signed [T_W-1:0] t_next [3];
    logic [RAD_W-1:0]      rad1_reg, rad2_reg, rad3_reg;
    logic [REG_W-1:0]      axes [3];

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v3_reg;
    assign rad_out   = rad3_reg;

    assign axes[0] = cfg.axis0;
    assign axes[1] = cfg.axis1;
    assign axes[2] = cfg.axis2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d_next[c] = DW'($signed(sphere[c])) - DW'(slot(cfg.center, c));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[i][c] = PRW'(d1_reg[c]) * PRW'(slot(axes[i], c));
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] dot;
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] h;
        for (int i = 0; i < 3; i++) begin
            dot = SW'(prod_reg[i][0]) + SW'(prod_reg[i][1]) + SW'(prod_reg[i][2]);
            p   = dot >>> AXIS_FRAC_BITS;
            h   = SW'($signed({1'b0, half_slot(cfg.half, i)}));
            if (p > h) begin
                t_next[i] = $signed(h[T_W-1:0]);
            end else if (p < -h) begin
                t_next[i] = $signed(-h[T_W-1:0]);
            end else begin
                t_next[i] = $signed(p[T_W-1:0]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            d_out[c] = d3_reg[c];
            t_out[c] = t_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_reg   <= d_next;
            rad1_reg <= radius;
        end
        if (en2) begin
            d2_reg   <= d1_reg;
            prod_reg <= prod_next;
            rad2_reg <= rad1_reg;
        end
        if (en3) begin
            d3_reg   <= d2_reg;
            t_reg    <= t_next;
            rad3_reg <= rad2_reg;
        end
    end

endmodule

/* rtl/sobb_recon.sv */
module sobb_recon
    import sobb_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int AXIS_FRAC_BITS = 14,
    localparam int DW = d_width(COORD_WIDTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0][DW-1:0]  d_in,
    input  logic [2:0][T_W-1:0] t_in,
    input  logic [RAD_W-1:0]    rad_in,
    input  sobb_cfg_t           cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0][R_W-1:0] r_out,
    output logic                far_out,
    output logic [RAD_W-1:0]    rad_out
);

    localparam int RW = ((DW > O_W) ? DW : O_W) + 1;
    localparam logic signed [RW-1:0] R_MAX = RW'(FAR_MAX);

    logic v1_reg, v2_reg;
    logic en1, en2;

    logic signed [Q_W-1:0] q_reg  [3][3];
    logic signed [Q_W-1:0] q_next [3][3];
    logic signed [DW-1:0]  d1_reg [3];
    logic signed [R_W-1:0] r_reg  [3];
    logic signed [R_W-1:0] r_next [3];
    logic                  far_reg, far_next;
    logic [RAD_W-1:0]      rad1_reg, rad2_reg;
    logic [REG_W-1:0]      axes [3];

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign far_out   = far_reg;
    assign rad_out   = rad2_reg;

    assign axes[0] = cfg.axis0;
    assign axes[1] = cfg.axis1;
    assign axes[2] = cfg.axis2;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                q_next[c][i] = Q_W'(slot(axes[i], c)) * Q_W'($signed(t_in[i]));
            end
        end
    end

    always_comb begin
        logic signed [O_W-1:0] osum;
        logic signed [O_W-1:0] o;
        logic signed [RW-1:0]  r;
        far_next = 1'b0;
        for (int c = 0; c < 3; c++) begin
            osum = O_W'(q_reg[c][0]) + O_W'(q_reg[c][1]) + O_W'(q_reg[c][2]);
            o    = osum >>> AXIS_FRAC_BITS;
            r    = RW'(d1_reg[c]) - RW'(o);
            if (r > R_MAX || r < -R_MAX) begin
                far_next = 1'b1;
            end
            r_next[c] = $signed(r[R_W-1:0]);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            r_out[c] = r_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            q_reg    <= q_next;
            rad1_reg <= rad_in;
            for (int c = 0; c < 3; c++) begin
                d1_reg[c] <= $signed(d_in[c]);
            end
        end
        if (en2) begin
            r_reg    <= r_next;
            far_reg  <= far_next;
            rad2_reg <= rad1_reg;
        end
    end

endmodule

/* rtl/sobb_dist.sv */
module sobb_dist
    import sobb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0][R_W-1:0] r_in,
    input  logic                far_in,
    input  logic [RAD_W-1:0]    rad_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                hit_out
);

    logic v1_reg, v2_reg;
    logic en1, en2;

    logic [SQ_W-1:0] sq_reg  [3];
    logic [SQ_W-1:0] sq_next [3];
    logic [SQ_W-1:0] rsq_reg, rsq_next;
    logic            far1_reg;
    logic            hit_reg, hit_next;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign hit_out   = hit_reg;

    always_comb begin
        logic signed [2*R_W-1:0] prod;
        for (int c = 0; c < 3; c++) begin
            prod       = $signed(r_in[c]) * $signed(r_in[c]);
            sq_next[c] = prod[SQ_W-1:0];
        end
        rsq_next = SQ_W'(rad_in) * SQ_W'(rad_in);
    end

    always_comb begin
        logic [DIST_W-1:0] dist_sum;
        dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        hit_next = !far1_reg && (dist_sum <= DIST_W'(rsq_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            sq_reg   <= sq_next;
            rsq_reg  <= rsq_next;
            far1_reg <= far_in;
        end
        if (en2) begin
            hit_reg <= hit_next;
        end
    end

endmodule

/* rtl/sphere_obb_overlap_test.sv */
// An accepted input word reaches its result word through seven register stages:
// offset, first products, clamp, second products, residual, squares and the final
// compare.
// Throughput is one word per cycle; a stalled output holds only the stages behind it.
// Reset is synchronous and active low; it empties the pipeline and returns the
// configuration registers to their reset values.
module sphere_obb_overlap_test
    import sobb_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int AXIS_FRAC_BITS = 14,
    localparam int IN_W = ((3 * COORD_WIDTH + RAD_W + 7) / 8) * 8,
    localparam int DW = d_width(COORD_WIDTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, zero padding
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // hit, zero padding
    output logic [7:0]        m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    sobb_cfg_t                  cfg;
    logic [2:0][COORD_WIDTH-1:0] sphere;
    logic [RAD_W-1:0]           radius;

    logic                proj_valid, recon_ready;
    logic [2:0][DW-1:0]  proj_d;
    logic [2:0][T_W-1:0] proj_t;
    logic [RAD_W-1:0]    proj_rad;

    logic                recon_valid, dist_ready;
    logic [2:0][R_W-1:0] recon_r;
    logic                recon_far;
    logic [RAD_W-1:0]    recon_rad;

    logic                hit;

    assign pready = 1'b1;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sphere[c] = s_axis_tdata[c*COORD_WIDTH +: COORD_WIDTH];
        end
        radius = s_axis_tdata[3*COORD_WIDTH +: RAD_W];
    end

    assign m_axis_tdata = {7'b0, hit};

    sobb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sobb_proj #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .sphere    (sphere),
        .radius    (radius),
        .cfg       (cfg),
        .out_valid (proj_valid),
        .out_ready (recon_ready),
        .d_out     (proj_d),
        .t_out     (proj_t),
        .rad_out   (proj_rad)
    );

    sobb_recon #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_recon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (proj_valid),
        .in_ready  (recon_ready),
        .d_in      (proj_d),
        .t_in      (proj_t),
        .rad_in    (proj_rad),
        .cfg       (cfg),
        .out_valid (recon_valid),
        .out_ready (dist_ready),
        .r_out     (recon_r),
        .far_out   (recon_far),
        .rad_out   (recon_rad)
    );

    sobb_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (recon_valid),
        .in_ready  (dist_ready),
        .r_in      (recon_r),
        .far_in    (recon_far),
        .rad_in    (recon_rad),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .hit_out   (hit)
    );

    a_empty_output_ready : assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("Input stalled although the output stage is empty.");

    a_cfg_reset : assert property (
        @(posedge aclk)
        !aresetn |=> (cfg.axis0 == AXIS0_RST && cfg.axis1 == AXIS1_RST &&
                      cfg.axis2 == AXIS2_RST && cfg.center == '0 && cfg.half == '0)
    ) else $error("Configuration registers did not return to their reset values.");

    a_center_write : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && sobb_reg_t'(paddr[ADDR_W-1:3]) == REG_CENTER)
        |=> cfg.center == $past(pwdata[REG_W-1:0])
    ) else $error("Box center write was not captured.");

endmodule

/* bench/sphere_obb_overlap_test_tb.sv */
module sphere_obb_overlap_test_tb;
    import sobb_pkg::*;

    localparam int AXIS_SHIFT = 14;
    localparam longint FAR_REACH = 32768;
    localparam int REG_STRIDE = 8;
    localparam int NUM_REGS = 5;
    localparam int RANDOM_PHASES = 6;
    localparam int SPHERES_PER_PHASE = 175;
    localparam int SETTLE_CYCLES = 12;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int MAX_PRINTED = 30;
    localparam logic [15:0] AXIS_ONE = 16'h4000;
    localparam logic [15:0] AXIS_DIAG = 16'd11585;

    class sphere_box_scoreboard;
        logic [47:0] box_reg [NUM_REGS];
        bit hit_q [$];
        int tests_noted;
        int hits_seen;

        function new();
            box_reg[REG_CENTER] = 48'h0;
            box_reg[REG_AXIS0] = 48'h0000_0000_4000;
            box_reg[REG_AXIS1] = 48'h0000_4000_0000;
            box_reg[REG_AXIS2] = 48'h4000_0000_0000;
            box_reg[REG_HALF] = 48'h0;
            tests_noted = 0;
            hits_seen = 0;
        endfunction

        function void write_register(input int idx, input logic [63:0] value);
            if (idx < NUM_REGS) begin
                box_reg[idx] = value[47:0];
            end
        endfunction

        function longint slot_value(input logic [47:0] w, input int k);
            return longint'($signed(w[k*16 +: 16]));
        endfunction

        function bit predict_hit(input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [15:0] sz, input logic [14:0] rad);
            logic [15:0] pos [3];
            longint d [3];
            longint a [3][3];
            longint t [3];
            longint acc;
            longint lim;
            longint r;
            longint dist2;
            longint rr;
            bit far;
            pos[0] = sx;
            pos[1] = sy;
            pos[2] = sz;
            far = 1'b0;
            dist2 = 0;
            for (int c = 0; c < 3; c++) begin
                d[c] = longint'($signed(pos[c])) - slot_value(box_reg[REG_CENTER], c);
            end
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    a[i][c] = slot_value(box_reg[int'(REG_AXIS0) + i], c);
                end
            end
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int c = 0; c < 3; c++) begin
                    acc += d[c] * a[i][c];
                end
                acc = acc >>> AXIS_SHIFT;
                lim = longint'(box_reg[REG_HALF][i*16 +: 15]);
                if (acc > lim) begin
                    acc = lim;
                end else if (acc < -lim) begin
                    acc = -lim;
                end
                t[i] = acc;
            end
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) begin
                    acc += a[i][c] * t[i];
                end
                r = d[c] - (acc >>> AXIS_SHIFT);
                if (r >= FAR_REACH || r <= -FAR_REACH) begin
                    far = 1'b1;
                end else begin
                    dist2 += r * r;
                end
            end
            rr = longint'(rad) * longint'(rad);
            return !far && (dist2 <= rr);
        endfunction

        function void note_sphere(input logic [63:0] word);
            hit_q.push_back(predict_hit(word[15:0], word[31:16], word[47:32], word[62:48]));
            tests_noted++;
        endfunction

        function bit check_hit(input logic got, output string why);
            bit want;
            why = "";
            if (hit_q.size() == 0) begin
                why = $sformatf("result word hit=%b arrived with no test pending", got);
                return 1'b0;
            end
            want = hit_q.pop_front();
            if (want) begin
                hits_seen++;
            end
            if (got !== want) begin
                why = $sformatf("hit is %b, expected %b", got, want);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return hit_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // sphere_x, sphere_y, sphere_z, sphere_radius, zero padding
    logic [63:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // hit, zero padding
    logic [7:0] m_axis_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    sphere_box_scoreboard sb = new();
    int errors = 0;
    int settings_used = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    int stall_left = 0;
    logic [15:0] cur_center [3];
    int cur_span = 256;

    sphere_obb_overlap_test u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string why);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $time, why);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_sphere(s_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        string why;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (!sb.check_hit(m_axis_tdata[0], why)) begin
                report_mismatch(why);
            end
        end
    end

    task automatic send_sphere(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic [14:0] rad);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, rad, z, y, x};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input int idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(REG_STRIDE * idx);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_box(input logic [47:0] center, input logic [47:0] ax0,
                             input logic [47:0] ax1, input logic [47:0] ax2,
                             input logic [47:0] half);
        wait_idle();
        write_reg(NUM_REGS + $urandom_range(0, 2), {$urandom, $urandom});
        write_reg(REG_CENTER, {16'($urandom), center});
        write_reg(REG_AXIS0, {16'($urandom), ax0});
        write_reg(REG_AXIS1, {16'($urandom), ax1});
        write_reg(REG_AXIS2, {16'($urandom), ax2});
        write_reg(REG_HALF, {16'($urandom), half});
        for (int c = 0; c < 3; c++) begin
            cur_center[c] = center[c*16 +: 16];
        end
        cur_span = int'(half[14:0]) + int'(half[30:16]) + int'(half[46:32]) + 256;
        settings_used++;
    endtask

    task automatic make_axes(input int style, output logic [47:0] ax0,
                             output logic [47:0] ax1, output logic [47:0] ax2);
        logic [15:0] comp [3][3];
        int k;
        int pos;
        bit swap;
        k = $urandom_range(0, 2);
        swap = 1'($urandom);
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                comp[i][c] = (style == 2) ? 16'($urandom) : 16'h0;
            end
        end
        if (style == 0) begin
            for (int i = 0; i < 3; i++) begin
                pos = (swap && i > 0) ? ((3 - i + k) % 3) : ((i + k) % 3);
                comp[i][pos] = $urandom_range(0, 1) ? -AXIS_ONE : AXIS_ONE;
            end
        end else if (style == 1) begin
            comp[0][k] = AXIS_DIAG;
            comp[0][(k + 1) % 3] = AXIS_DIAG;
            comp[1][k] = -AXIS_DIAG;
            comp[1][(k + 1) % 3] = AXIS_DIAG;
            comp[2][(k + 2) % 3] = AXIS_ONE;
        end
        ax0 = {comp[0][2], comp[0][1], comp[0][0]};
        ax1 = {comp[1][2], comp[1][1], comp[1][0]};
        ax2 = {comp[2][2], comp[2][1], comp[2][0]};
    endtask

    task automatic random_box(input int phase);
        logic [47:0] center;
        logic [47:0] half;
        logic [47:0] ax0;
        logic [47:0] ax1;
        logic [47:0] ax2;
        for (int c = 0; c < 3; c++) begin
            center[c*16 +: 16] = 16'(int'($urandom_range(0, 8191)) - 4096);
            half[c*16 +: 16] = {1'($urandom), ($urandom_range(0, 3) == 0)
                                ? 15'($urandom) : 15'($urandom_range(0, 2047))};
        end
        make_axes(phase % 3, ax0, ax1, ax2);
        if (phase == 4) begin
            ax1 = 48'h0;
        end
        apply_box(center, ax0, ax1, ax2, half);
    endtask

    task automatic random_sphere();
        logic [15:0] pos [3];
        logic [14:0] rad;
        int off;
        int roll;
        for (int c = 0; c < 3; c++) begin
            if ($urandom_range(0, 99) < 80) begin
                off = int'($urandom_range(0, 2 * cur_span)) - cur_span;
                pos[c] = 16'(int'($signed(cur_center[c])) + off);
            end else begin
                pos[c] = 16'($urandom);
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            rad = 15'($urandom_range(0, 1023));
        end else if (roll < 90) begin
            rad = 15'($urandom_range(0, 8191));
        end else begin
            rad = 15'($urandom);
        end
        send_sphere(pos[0], pos[1], pos[2], rad);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int c = 0; c < 3; c++) begin
            cur_center[c] = 16'h0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        settings_used = 1;

        // Box after reset: a single point at the origin with unit axes.
        send_sphere(16'd0, 16'd0, 16'd0, 15'd0);
        send_sphere(16'd16, 16'd0, 16'd0, 15'd16);
        send_sphere(16'd16, 16'd0, 16'd0, 15'd15);
        send_sphere(16'h7FFF, 16'h8000, 16'd0, 15'h7FFF);
        send_sphere(16'h8000, 16'h8000, 16'h8000, 15'h7FFF);
        send_sphere(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0);
        send_sphere(16'd0, 16'd0, 16'd0, 15'h7FFF);

        // Axis-aligned box with one ignored top bit in the half extents.
        apply_box({16'd300, 16'hFF38, 16'd100}, 48'h0000_0000_4000,
                  48'h0000_4000_0000, 48'h4000_0000_0000,
                  {16'd480, 16'h8000 | 16'd320, 16'd160});
        send_sphere(16'd100, 16'hFF38, 16'd300, 15'd0);
        send_sphere(16'd260, 16'hFF38, 16'd300, 15'd0);
        send_sphere(16'd261, 16'hFF38, 16'd300, 15'd0);
        send_sphere(16'd276, 16'hFF38, 16'd300, 15'd16);
        send_sphere(16'd276, 16'hFF38, 16'd300, 15'd15);
        send_sphere(16'd270, 16'hFDEE, 16'd790, 15'd18);
        send_sphere(16'd270, 16'hFDEE, 16'd790, 15'd17);

        // Extreme axes, a zero axis, full half extents and a far center.
        apply_box(48'h8000_7FFF_8000, 48'h8000_7FFF_8000, 48'h7FFF_7FFF_7FFF,
                  48'h0, 48'hFFFF_7FFF_FFFF);
        send_sphere(16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF);
        send_sphere(16'h8000, 16'h7FFF, 16'h8000, 15'd0);
        send_sphere(16'd0, 16'd0, 16'd0, 15'h4000);
        send_sphere(16'hFFFF, 16'h0001, 16'hFFFF, 15'h7FFF);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_box(ph);
            src_steady = (ph == 1);
            sink_steady = (ph == 1 || ph == 3);
            for (int n = 0; n < SPHERES_PER_PHASE; n++) begin
                random_sphere();
            end
        end

        wait_idle();
        $display("Ran %0d sphere tests over %0d box settings; %0d of them were hits.",
                 sb.tests_noted, settings_used, sb.hits_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sobb_pkg.sv
rtl/sobb_cfg.sv
rtl/sobb_proj.sv
rtl/sobb_recon.sv
rtl/sobb_dist.sv
rtl/sphere_obb_overlap_test.sv
bench/sphere_obb_overlap_test_tb.sv
